// ----- rtl/core/aiu_pkg.sv -----
// aiu_pkg: shared types, widths and helpers of the alphabet index unpacker.
// No dependencies; compiled first.
package aiu_pkg;

  localparam int BYTE_W = 8;   // stream byte and symbol width
  localparam int CNT_W  = 9;   // alphabet size and fill index (up to 256)
  localparam int CW_W   = 4;   // code width field (1..8)
  localparam int ACC_W  = 15;  // bit accumulator
  localparam int HELD_W = 4;   // bits held in the accumulator (0..15)

  // Stream phase
  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_TABLE  = 2'd1,
    PH_UNPACK = 2'd2
  } phase_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_byte;  // accepted request: header, table or code byte
    logic take_code;  // pop one code off the accumulator
    logic pend_load;  // capture table read data into the pending slot
    logic out_load;   // move pending symbol into the output register
    logic out_last;   // flag for the symbol moved by out_load
  } aiu_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic unpack_byte;  // incoming byte carries packed codes
    logic code_ready;   // at least one whole code is held
    logic code_valid;   // the oldest code is below the alphabet size
    logic pend_valid;   // pending symbol waits
    logic out_free;     // output register can take a symbol this cycle
  } aiu_status_t;

  // Smallest width w in 1..8 with 2^w >= n
  function automatic logic [CW_W-1:0] width_for(logic [CNT_W-1:0] n);
    logic [CW_W-1:0] w;
    w = CW_W'(8);
    for (int i = 7; i >= 1; i--) begin
      if ((CNT_W'(1) << i) >= n) w = CW_W'(i);
    end
    return w;
  endfunction

endpackage

// ----- rtl/core/aiu_if.sv -----
// aiu_if: valid/ready channel interfaces for input bytes and decoded symbols.
// Depends on aiu_pkg.
interface aiu_in_if;
  import aiu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              first_byte;

  modport source (output valid, output stream_byte, output first_byte, input ready);
  modport sink   (input valid, input stream_byte, input first_byte, output ready);
endinterface

interface aiu_out_if;
  import aiu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] symbol;
  logic              last_of_run;

  modport source (output valid, output symbol, output last_of_run, input ready);
  modport sink   (input valid, input symbol, input last_of_run, output ready);
endinterface

// ----- rtl/core/aiu_ram.sv -----
// aiu_ram: generic single-port RAM, one write or one read per cycle,
// registered read data. No dependencies.
module aiu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/aiu_ctrl.sv -----
// aiu_ctrl: sequencing state machine of the unpacker.
// Depends on aiu_pkg; drives aiu_datapath through aiu_cmd_t.
module aiu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aiu_pkg::aiu_status_t status_i,
  output aiu_pkg::aiu_cmd_t    cmd_o
);
  import aiu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,  // waiting for a byte
    ST_EXTRACT = 4'b0010,  // pop codes off the accumulator
    ST_READ    = 4'b0100,  // table data valid, park it in the pending slot
    ST_FLUSH   = 4'b1000   // send the final symbol of the byte
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          if (status_i.unpack_byte) state_d = ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        if (status_i.code_ready) begin
          cmd_o.take_code = 1'b1;
          if (status_i.code_valid) state_d = ST_READ;
        end else if (status_i.pend_valid) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        // earlier symbol is not the last: move it to the output as the new one is parked
        if (!status_i.pend_valid) begin
          cmd_o.pend_load = 1'b1;
          state_d         = ST_EXTRACT;
        end else if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.pend_load = 1'b1;
          state_d         = ST_EXTRACT;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/aiu_datapath.sv -----
// aiu_datapath: stream registers, bit accumulator, symbol table, pending
// slot and output register. Depends on aiu_pkg and aiu_ram.
module aiu_datapath #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [aiu_pkg::BYTE_W-1:0]  stream_byte_i,
  input  logic                        first_byte_i,
  input  aiu_pkg::aiu_cmd_t           cmd_i,
  output aiu_pkg::aiu_status_t        status_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [aiu_pkg::BYTE_W-1:0]  symbol_o,
  output logic                        last_of_run_o
);
  import aiu_pkg::*;

  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam logic [CNT_W-1:0] MaxN = CNT_W'(MAX_SYMBOLS);

  phase_e            phase_q;
  logic [CNT_W-1:0]  n_q, fill_q;
  logic [CW_W-1:0]   w_q;
  logic [ACC_W-1:0]  acc_q;
  logic [HELD_W-1:0] held_q;
  logic              pend_valid_q, out_valid_q;
  logic [BYTE_W-1:0] pend_sym_q, out_sym_q;
  logic              out_last_q;

  logic [CNT_W-1:0]  n_raw, n_new, fill_inc;
  logic [HELD_W-1:0] rest;
  logic [ACC_W-1:0]  shifted, keep_mask;
  logic [BYTE_W-1:0] code, code_mask, rdata;
  logic              code_valid, tbl_we, tbl_re, out_free;
  logic [IDX_W-1:0]  tbl_addr;

  // Count byte decode: zero means 256, saturate at the table depth
  assign n_raw = (stream_byte_i == '0) ? CNT_W'(256) : {1'b0, stream_byte_i};
  assign n_new = (n_raw > MaxN) ? MaxN : n_raw;
  assign fill_inc = fill_q + CNT_W'(1);

  // Oldest whole code sits just above the remaining bits
  assign rest       = held_q - HELD_W'(w_q);
  assign shifted    = acc_q >> rest;
  assign code_mask  = BYTE_W'((CNT_W'(1) << w_q) - CNT_W'(1));
  assign code       = shifted[BYTE_W-1:0] & code_mask;
  assign keep_mask  = (ACC_W'(1) << rest) - ACC_W'(1);
  assign code_valid = ({1'b0, code} < n_q);

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.unpack_byte = !first_byte_i && (phase_q == PH_UNPACK);
  assign status_o.code_ready  = (held_q >= HELD_W'(w_q));
  assign status_o.code_valid  = code_valid;
  assign status_o.pend_valid  = pend_valid_q;
  assign status_o.out_free    = out_free;

  // Symbol table: written while loading, read per code below the alphabet size
  assign tbl_we   = cmd_i.load_byte && !first_byte_i && (phase_q == PH_TABLE);
  assign tbl_re   = cmd_i.take_code && code_valid;
  assign tbl_addr = tbl_we ? fill_q[IDX_W-1:0] : code[IDX_W-1:0];

  aiu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (tbl_re),
    .addr_i  (tbl_addr),
    .wdata_i (stream_byte_i),
    .rdata_o (rdata)
  );

  // Stream state and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      n_q     <= '0;
      w_q     <= CW_W'(1);
      fill_q  <= '0;
      acc_q   <= '0;
      held_q  <= '0;
    end else if (cmd_i.load_byte) begin
      if (first_byte_i) begin
        phase_q <= PH_TABLE;
        n_q     <= n_new;
        w_q     <= width_for(n_new);
        fill_q  <= '0;
        acc_q   <= '0;
        held_q  <= '0;
      end else if (phase_q == PH_TABLE) begin
        fill_q <= fill_inc;
        if (fill_inc >= n_q) phase_q <= PH_UNPACK;
      end else if (phase_q == PH_UNPACK) begin
        acc_q  <= {acc_q[ACC_W-BYTE_W-1:0], stream_byte_i};
        held_q <= held_q + HELD_W'(BYTE_W);
      end
    end else if (cmd_i.take_code) begin
      acc_q  <= acc_q & keep_mask;
      held_q <= rest;
    end
  end

  // Pending and output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pend_load)     pend_valid_q <= 1'b1;
      else if (cmd_i.out_load) pend_valid_q <= 1'b0;
      if (cmd_i.out_load)      out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) pend_sym_q <= rdata;
    if (cmd_i.out_load) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = out_sym_q;
  assign last_of_run_o = out_last_q;

endmodule

// ----- rtl/core/alphabet_index_unpacker.sv -----
// Channel   Dir  Payload                      Accepted when
// in_i      in   stream_byte[8], first_byte   in_i.valid && in_i.ready
// out_o     out  symbol[8], last_of_run       out_o.valid && out_o.ready
//
// Count, table and ignored bytes are each taken without leaving IDLE. A code
// byte is loaded, then its codes are popped one by one; each code that hits the
// table is read from the single-port table and parked, and when no whole code
// is left the final symbol is sent. Input is taken only between bytes.
// Reset (async, low) returns to waiting for a count byte; the table is not
// cleared. A stalled output holds the decoder once the pending slot is full.
//
// alphabet_index_unpacker: top level, ties controller and datapath together.
// Depends on aiu_pkg, aiu_if, aiu_ctrl, aiu_datapath.
module alphabet_index_unpacker #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  aiu_in_if.sink   in_i,
  aiu_out_if.source out_o
);
  import aiu_pkg::*;

  aiu_cmd_t    cmd;
  aiu_status_t status;

  aiu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aiu_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stream_byte_i (in_i.stream_byte),
    .first_byte_i  (in_i.first_byte),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .symbol_o      (out_o.symbol),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

// ----- rtl/core/aiu_checker.sv -----
// aiu_checker: port-level assertions for alphabet_index_unpacker, with bind.
// Depends on aiu_pkg and the top level's ports.
module aiu_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       first_byte_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [aiu_pkg::BYTE_W-1:0] symbol_i,
  input logic                       last_of_run_i
);

  // A stalled symbol stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(symbol_i)
      && $stable(last_of_run_i))
    else $error("stalled output request changed");

  // No output right after a reset edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // A count byte leaves the input ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && first_byte_i |=> in_ready_i)
    else $error("count byte held the input");

  // A count byte yields no symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && first_byte_i |=>
      (!out_valid_i || $past(out_valid_i && !out_ready_i)))
    else $error("symbol produced by a count byte");

endmodule

bind alphabet_index_unpacker aiu_checker u_aiu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .first_byte_i  (in_i.first_byte),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .symbol_i      (out_o.symbol),
  .last_of_run_i (out_o.last_of_run)
);
